>>> rtl/dpsc_pkg.sv
package dpsc_pkg;

    localparam int unsigned DPAD_W = 4;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned MEM_W  = 2;

    // Mode register codes
    localparam logic [MODE_W-1:0] MODE_NEUTRAL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UP      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIRST   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BYPASS  = 3'd4;

    // Per-axis memory codes
    localparam logic [MEM_W-1:0] MEM_NONE   = 2'd0;
    localparam logic [MEM_W-1:0] MEM_FIRST  = 2'd1;
    localparam logic [MEM_W-1:0] MEM_SECOND = 2'd2;

    typedef struct packed {
        logic [1:0]       bits;  // bit0 first direction, bit1 second
        logic [MEM_W-1:0] mem;
    } axis_res_t;

    // Resolve one axis; pair bit0 is up/left, bit1 is down/right.
    function automatic axis_res_t resolve_axis(
        input logic [1:0]        pair,
        input logic [MODE_W-1:0] mode,
        input logic              allow_up,
        input logic [MEM_W-1:0]  mem
    );
        axis_res_t r;
        r.bits = 2'b00;
        r.mem  = mem;
        case (pair)
            2'b01:
            begin
                r.bits = 2'b01;
                r.mem  = MEM_FIRST;
            end
            2'b10:
            begin
                r.bits = 2'b10;
                r.mem  = MEM_SECOND;
            end
            2'b00:
            begin
                r.bits = 2'b00;
                r.mem  = MEM_NONE;
            end
            default:
            begin
                if (allow_up && mode == MODE_UP)
                begin
                    r.bits = 2'b01;
                    r.mem  = MEM_FIRST;
                end
                else if (mode == MODE_SECOND && mem != MEM_NONE)
                begin
                    r.bits = (mem == MEM_FIRST) ? 2'b10 : 2'b01;
                end
                else if (mode == MODE_FIRST && mem != MEM_NONE)
                begin
                    r.bits = (mem == MEM_FIRST) ? 2'b01 : 2'b10;
                end
                else
                begin
                    r.bits = 2'b00;
                    r.mem  = MEM_NONE;
                end
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/dpad_socd_cleaner_unit.sv
// An accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls; the input register feeds
// the result register via per-axis resolve logic, and both stages advance together.
// Reset (rst_n low, asynchronous): both stage valids clear, mode returns to neutral,
// and the vertical and horizontal memories return to none.
module dpad_socd_cleaner_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,       // socd_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [3:0] dpad_in, [7:4] zero
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata     // [3:0] dpad_out, [7:4] zero
);
    import dpsc_pkg::*;

    // Configuration
    logic [MODE_W-1:0] mode_reg;

    // Input stage
    logic              in_vld_reg;
    logic [DPAD_W-1:0] in_data_reg;

    // Result stage
    logic              out_vld_reg;
    logic [DPAD_W-1:0] out_data_reg;

    // Per-axis memory of the last lone direction
    logic [MEM_W-1:0]  last_vert_reg;
    logic [MEM_W-1:0]  last_horz_reg;
    logic [MEM_W-1:0]  last_vert_next;
    logic [MEM_W-1:0]  last_horz_next;

    logic              in_take;
    logic              adv;
    axis_res_t         vert_res;
    axis_res_t         horz_res;
    logic [DPAD_W-1:0] out_data_next;

    // Advance the input stage whenever the result register is empty or drains now.
    assign adv           = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Resolve both axes from the held sample and the remembered directions.
    always_comb
    begin
        vert_res = resolve_axis(in_data_reg[1:0], mode_reg, 1'b1, last_vert_reg);
        horz_res = resolve_axis(in_data_reg[3:2], mode_reg, 1'b0, last_horz_reg);
        if (mode_reg == MODE_BYPASS)
        begin
            // Pass the sample through and leave the memory alone.
            out_data_next  = in_data_reg;
            last_vert_next = last_vert_reg;
            last_horz_next = last_horz_reg;
        end
        else
        begin
            out_data_next  = {horz_res.bits, vert_res.bits};
            last_vert_next = vert_res.mem;
            last_horz_next = horz_res.mem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NEUTRAL;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            last_vert_reg <= MEM_NONE;
            last_horz_reg <= MEM_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end

            // Hold the input stage while stalled; refill or drain it otherwise.
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_vld_reg <= 1'b0;
            end

            if (adv)
            begin
                out_vld_reg   <= 1'b1;
                last_vert_reg <= last_vert_next;
                last_horz_reg <= last_horz_next;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_axis_tdata[DPAD_W-1:0];
        end
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, out_data_reg};

    // The memory code for "both" never arises.
    a_vert_mem_legal: assert property (@(posedge clk) disable iff (!rst_n)
        last_vert_reg != 2'd3)
        else $error("vertical memory holds an unused code");

    a_horz_mem_legal: assert property (@(posedge clk) disable iff (!rst_n)
        last_horz_reg != 2'd3)
        else $error("horizontal memory holds an unused code");

    // Bypass leaves both memories untouched.
    a_bypass_keeps_mem: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_BYPASS) |=> ($stable(last_vert_reg) && $stable(last_horz_reg)))
        else $error("memory changed in bypass");

    // Outside bypass no axis conflict reaches the output.
    a_no_conflict_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && mode_reg != MODE_BYPASS) |=>
            (!(out_data_reg[0] && out_data_reg[1]) && !(out_data_reg[2] && out_data_reg[3])))
        else $error("opposing directions left in cleaned sample");

    // An advancing beat always lands in the result register.
    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_vld_reg)
        else $error("advanced beat lost");

endmodule
